// File: sv/cgpb_pkg.sv
// ----------------------------------------------------------------------------
// cgpb_pkg
// Shared types, codes and defaults of the clipped glyph pixel blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cgpb_pkg;

  // parameter defaults
  localparam int COLOUR_SETS_DEF  = 16;
  localparam int PIXEL_LEVELS_DEF = 15;
  localparam int ADDR_BITS_DEF    = 24;

  // largest source extent in either direction
  localparam int SRC_MAX = 64;

  // fixed port widths
  localparam int IN_DATA_W  = 56;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // placed coordinates and clip compares
  localparam int COORD_W = 14;
  localparam int CLIP_W  = 15;
  localparam int PROD_W  = 28;

  // item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PALETTE = 3'd0,
    MODE_NORMAL  = 3'd1,
    MODE_FAT     = 3'd2,
    MODE_HIGH    = 3'd3,
    MODE_BIG     = 3'd4
  } mode_e;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_X_OFFSET    = 3'd4,
    REG_Y_OFFSET    = 3'd5,
    REG_ROW_STRIDE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] clip_left;
    logic [11:0] clip_top;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [11:0] x_offset;
    logic [11:0] y_offset;
    logic [12:0] row_stride;
  } cfg_t;

  // one input word, unpacked
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [11:0]       glyph_x;
    logic [11:0]       glyph_y;
    logic [6:0]        glyph_width;
    logic [6:0]        glyph_height;
    logic [3:0]        colour_set;
    logic [3:0]        pixel;
    logic [7:0]        entry_value;
  } item_t;

  // placed opaque pixel handed from front end to emitter
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               copy_r;
    logic               copy_d;
  } pix_t;

endpackage

`default_nettype wire

// File: sv/cgpb_cfg_regs.sv
// ----------------------------------------------------------------------------
// cgpb_cfg_regs
// Configuration register file: clip rectangle, offsets and row stride.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpb_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cgpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cgpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cgpb_pkg::cfg_t                   cfg_o
);

  cgpb_pkg::cfg_t cfg_d, cfg_q;
  logic           wr;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  // register decoder
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cgpb_pkg::cfg_idx_e'(cfg_index_i))
        cgpb_pkg::REG_CLIP_LEFT:   cfg_d.clip_left   = cfg_data_i[11:0];
        cgpb_pkg::REG_CLIP_TOP:    cfg_d.clip_top    = cfg_data_i[11:0];
        cgpb_pkg::REG_CLIP_WIDTH:  cfg_d.clip_width  = cfg_data_i;
        cgpb_pkg::REG_CLIP_HEIGHT: cfg_d.clip_height = cfg_data_i;
        cgpb_pkg::REG_X_OFFSET:    cfg_d.x_offset    = cfg_data_i[11:0];
        cgpb_pkg::REG_Y_OFFSET:    cfg_d.y_offset    = cfg_data_i[11:0];
        cgpb_pkg::REG_ROW_STRIDE:  cfg_d.row_stride  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left   <= 12'd0;
      cfg_q.clip_top    <= 12'd0;
      cfg_q.clip_width  <= 13'd320;
      cfg_q.clip_height <= 13'd200;
      cfg_q.x_offset    <= 12'd0;
      cfg_q.y_offset    <= 12'd0;
      cfg_q.row_stride  <= 13'd320;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/cgpb_front.sv
// ----------------------------------------------------------------------------
// cgpb_front
// Input stage: mode decode, source column/row counters, placement and the
// palette memory (written by palette words, read once per opaque pixel).
// ----------------------------------------------------------------------------
`default_nettype none

module cgpb_front #(
  parameter int COLOUR_SETS  = cgpb_pkg::COLOUR_SETS_DEF,
  parameter int PIXEL_LEVELS = cgpb_pkg::PIXEL_LEVELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cgpb_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cgpb_pkg::item_t     item_i,
  output logic                pix_valid_o,
  output cgpb_pkg::pix_t      pix_o,
  output logic [7:0]          colour_o,
  input  logic                pix_take_i
);

  localparam int TABLE_SIZE = COLOUR_SETS * PIXEL_LEVELS;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // palette memory, one write or one read per cycle
  logic [7:0] pal_mem [TABLE_SIZE];
  logic [7:0] pal_rdata_q;

  logic        is_pal, is_glyph, hdbl, vdbl, copy_r, copy_d;
  logic [6:0]  src_w7, src_h7, src_w, src_h;
  logic        geo_ok, lv_ok, cs_ok;
  logic [15:0] idx_full;
  logic [IDX_W-1:0] pal_idx;
  logic        accept, pal_we, step, pal_re;
  logic [5:0]  col_d, col_q, row_d, row_q;
  logic [6:0]  col_sc, row_sc;
  logic [cgpb_pkg::COORD_W-1:0] x_d, y_d;
  logic        pv_d, pv_q;
  cgpb_pkg::pix_t pix_d, pix_q;

  // mode decode
  always_comb begin
    is_pal   = 1'b0;
    is_glyph = 1'b0;
    hdbl     = 1'b0;
    vdbl     = 1'b0;
    copy_r   = 1'b0;
    copy_d   = 1'b0;
    unique case (item_i.mode)
      cgpb_pkg::MODE_PALETTE: is_pal = 1'b1;
      cgpb_pkg::MODE_NORMAL:  is_glyph = 1'b1;
      cgpb_pkg::MODE_FAT: begin
        is_glyph = 1'b1;
        copy_r   = 1'b1;
      end
      cgpb_pkg::MODE_HIGH: begin
        is_glyph = 1'b1;
        vdbl     = 1'b1;
        copy_d   = 1'b1;
      end
      cgpb_pkg::MODE_BIG: begin
        is_glyph = 1'b1;
        hdbl     = 1'b1;
        vdbl     = 1'b1;
        copy_r   = 1'b1;
        copy_d   = 1'b1;
      end
      default: ;
    endcase
  end

  // source extent, halved for doubled directions and capped
  always_comb begin
    src_w7 = hdbl ? {1'b0, item_i.glyph_width[6:1]} : item_i.glyph_width;
    src_h7 = vdbl ? {1'b0, item_i.glyph_height[6:1]} : item_i.glyph_height;
    src_w  = (src_w7 > 7'(cgpb_pkg::SRC_MAX)) ? 7'(cgpb_pkg::SRC_MAX) : src_w7;
    src_h  = (src_h7 > 7'(cgpb_pkg::SRC_MAX)) ? 7'(cgpb_pkg::SRC_MAX) : src_h7;
    geo_ok = (src_w != 7'd0) && (src_h != 7'd0);
  end

  // palette entry select
  assign lv_ok    = (item_i.pixel != 4'd0) && (8'(item_i.pixel) <= 8'(PIXEL_LEVELS));
  assign cs_ok    = 9'(item_i.colour_set) < 9'(COLOUR_SETS);
  assign idx_full = 16'(item_i.colour_set) * 16'(PIXEL_LEVELS) + 16'(item_i.pixel) - 16'd1;
  assign pal_idx  = idx_full[IDX_W-1:0];

  assign accept     = in_valid_i && in_ready_o;
  assign pal_we     = accept && is_pal && lv_ok && cs_ok;
  assign step       = accept && is_glyph && geo_ok;
  assign pal_re     = step && lv_ok && cs_ok;
  assign in_ready_o = !pv_q || pix_take_i;

  // a write lands at the edge it is accepted, so any later read sees it
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[pal_idx] <= item_i.entry_value;
    end
    if (pal_re) begin
      pal_rdata_q <= pal_mem[pal_idx];
    end
  end

  // column and row counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step) begin
      if ((7'(col_q) + 7'd1) >= src_w) begin
        col_d = 6'd0;
        row_d = ((7'(row_q) + 7'd1) >= src_h) ? 6'd0 : row_q + 6'd1;
      end else begin
        col_d = col_q + 6'd1;
      end
    end
  end

  // placed position of the current source pixel
  always_comb begin
    col_sc = hdbl ? {col_q, 1'b0} : {1'b0, col_q};
    row_sc = vdbl ? {row_q, 1'b0} : {1'b0, row_q};
    x_d = {{2{item_i.glyph_x[11]}}, item_i.glyph_x}
        + {{2{cfg_i.x_offset[11]}}, cfg_i.x_offset}
        + {7'd0, col_sc};
    y_d = {{2{item_i.glyph_y[11]}}, item_i.glyph_y}
        + {{2{cfg_i.y_offset[11]}}, cfg_i.y_offset}
        + {7'd0, row_sc};
    pix_d.x      = x_d;
    pix_d.y      = y_d;
    pix_d.copy_r = copy_r;
    pix_d.copy_d = copy_d;
  end

  // stage valid
  always_comb begin
    if (pal_re) begin
      pv_d = 1'b1;
    end else if (pix_take_i) begin
      pv_d = 1'b0;
    end else begin
      pv_d = pv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 6'd0;
      row_q <= 6'd0;
      pv_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      pix_q <= pix_d;
    end
  end

  assign pix_valid_o = pv_q;
  assign pix_o       = pix_q;
  assign colour_o    = pal_rdata_q;

endmodule

`default_nettype wire

// File: sv/cgpb_emit.sv
// ----------------------------------------------------------------------------
// cgpb_emit
// Clip test of the up to four output pixels, row address product, and the
// write sequencer that sends one framebuffer word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpb_emit #(
  parameter int ADDR_BITS = cgpb_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cgpb_pkg::cfg_t       cfg_i,
  input  logic                 pix_valid_i,
  input  cgpb_pkg::pix_t       pix_i,
  input  logic [7:0]           colour_i,
  output logic                 pix_take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_BITS-1:0] out_addr_o,
  output logic [7:0]           out_data_o,
  output logic                 out_last_o
);

  logic signed [cgpb_pkg::CLIP_W-1:0] x0, x1, y0, y1;
  logic signed [cgpb_pkg::CLIP_W-1:0] left, right, top, bottom;
  logic [13:0] right14, bottom14;
  logic        xin0, xin1, yin0, yin1;
  logic [3:0]  mask;
  logic signed [cgpb_pkg::PROD_W-1:0] prod;
  logic [ADDR_BITS-1:0] base_d;

  logic                 busy_d, busy_q;
  logic [3:0]           mask_d, mask_q;
  logic [ADDR_BITS-1:0] base_q;
  logic [7:0]           colour_q;

  logic [3:0]           sel, rem;
  logic                 sel_dx, sel_dy;
  logic [ADDR_BITS-1:0] addr;
  logic                 fire, done, free, load;
  logic                 ov_d, ov_q;
  logic [ADDR_BITS-1:0] oaddr_q;
  logic [7:0]           odata_q;
  logic                 olast_q;

  // clip rectangle bounds, wide enough for any left plus width
  assign right14  = {2'b00, cfg_i.clip_left} + {1'b0, cfg_i.clip_width};
  assign bottom14 = {2'b00, cfg_i.clip_top} + {1'b0, cfg_i.clip_height};
  assign left     = $signed({3'b000, cfg_i.clip_left});
  assign top      = $signed({3'b000, cfg_i.clip_top});
  assign right    = $signed({1'b0, right14});
  assign bottom   = $signed({1'b0, bottom14});

  // candidate columns and rows
  assign x0 = $signed({pix_i.x[cgpb_pkg::COORD_W-1], pix_i.x});
  assign y0 = $signed({pix_i.y[cgpb_pkg::COORD_W-1], pix_i.y});
  assign x1 = x0 + 15'sd1;
  assign y1 = y0 + 15'sd1;

  assign xin0 = (x0 >= left) && (x0 < right);
  assign xin1 = (x1 >= left) && (x1 < right);
  assign yin0 = (y0 >= top) && (y0 < bottom);
  assign yin1 = (y1 >= top) && (y1 < bottom);

  // writes in order (x,y) (x+1,y) (x,y+1) (x+1,y+1)
  assign mask = {pix_i.copy_r && pix_i.copy_d && xin1 && yin1,
                 pix_i.copy_d && xin0 && yin1,
                 pix_i.copy_r && xin1 && yin0,
                 xin0 && yin0};

  // row base address: y * stride + x, modulo the address width
  assign prod   = $signed(pix_i.y) * $signed({1'b0, cfg_i.row_stride});
  assign base_d = ADDR_BITS'(prod) + ADDR_BITS'(x0);

  // lowest pending write
  always_comb begin
    if (mask_q[0]) begin
      sel = 4'b0001;
    end else if (mask_q[1]) begin
      sel = 4'b0010;
    end else if (mask_q[2]) begin
      sel = 4'b0100;
    end else begin
      sel = 4'b1000;
    end
    rem    = mask_q & ~sel;
    sel_dx = sel[1] || sel[3];
    sel_dy = sel[2] || sel[3];
  end

  assign addr = base_q
              + (sel_dy ? ADDR_BITS'(cfg_i.row_stride) : '0)
              + ADDR_BITS'(sel_dx);

  // handshake between stages
  assign fire       = busy_q && (!ov_q || out_ready_i);
  assign done       = fire && (rem == 4'd0);
  assign free       = !busy_q || done;
  assign pix_take_o = pix_valid_i && (free || (mask == 4'd0));
  assign load       = pix_valid_i && free && (mask != 4'd0);

  // sequencer state
  always_comb begin
    busy_d = busy_q;
    mask_d = mask_q;
    if (load) begin
      busy_d = 1'b1;
      mask_d = mask;
    end else if (fire) begin
      busy_d = !done;
      mask_d = rem;
    end
  end

  // output register
  always_comb begin
    if (fire) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mask_q <= 4'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mask_q <= mask_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q   <= base_d;
      colour_q <= colour_i;
    end
    if (fire) begin
      oaddr_q <= addr;
      odata_q <= colour_q;
      olast_q <= (rem == 4'd0);
    end
  end

  assign out_valid_o = ov_q;
  assign out_addr_o  = oaddr_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;

endmodule

`default_nettype wire

// File: sv/clipped_glyph_pixel_blit.sv
// ----------------------------------------------------------------------------
// clipped_glyph_pixel_blit
// Palette-mapped, clipped glyph blitter producing framebuffer byte writes.
// ----------------------------------------------------------------------------
// Glyph pixels arrive in raster order, one per word; the block keeps its own
// source column and row. Each opaque pixel is looked up in the palette
// memory and sent as up to four framebuffer words (the fat, high and big
// copies), each tested on its own against the clip rectangle. The emitter
// owns the single output port and sends one word per cycle while the output
// is not stalled, staying busy with a pixel until all its writes are out;
// palette words, transparent and fully clipped pixels never occupy it. The
// next input word is taken while the emitter is still busy with the previous
// pixel. A first write passes the front stage, sequencer and output registers.
// The palette is undefined until written; there is no clearing pass after reset.
`default_nettype none

module clipped_glyph_pixel_blit #(
  parameter int COLOUR_SETS  = cgpb_pkg::COLOUR_SETS_DEF,
  parameter int PIXEL_LEVELS = cgpb_pkg::PIXEL_LEVELS_DEF,
  parameter int ADDR_BITS    = cgpb_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // glyph_x[11:0] glyph_y[23:12] glyph_width[30:24] glyph_height[37:31]
  // colour_set[41:38] pixel[45:42] entry_value[53:46], zero pad above
  input  logic [cgpb_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // mode[2:0]
  input  logic [cgpb_pkg::MODE_W-1:0]           s_axis_tuser,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // write_addr[ADDR_BITS-1:0] write_data[ADDR_BITS+7:ADDR_BITS], zero pad
  output logic [((ADDR_BITS+15)/8)*8-1:0]       m_axis_tdata,
  // last_write
  output logic                                  m_axis_tlast,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [cgpb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cgpb_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int OUT_W = ((ADDR_BITS + 15) / 8) * 8;

  cgpb_pkg::cfg_t  cfg;
  cgpb_pkg::item_t item;
  cgpb_pkg::pix_t  pix;
  logic            pix_valid, pix_take;
  logic [7:0]      colour;
  logic [ADDR_BITS-1:0] out_addr;
  logic [7:0]      out_data;

  // unpack input word
  assign item.mode         = s_axis_tuser;
  assign item.glyph_x      = s_axis_tdata[11:0];
  assign item.glyph_y      = s_axis_tdata[23:12];
  assign item.glyph_width  = s_axis_tdata[30:24];
  assign item.glyph_height = s_axis_tdata[37:31];
  assign item.colour_set   = s_axis_tdata[41:38];
  assign item.pixel        = s_axis_tdata[45:42];
  assign item.entry_value  = s_axis_tdata[53:46];

  cgpb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cgpb_front #(
    .COLOUR_SETS  (COLOUR_SETS),
    .PIXEL_LEVELS (PIXEL_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .pix_valid_o (pix_valid),
    .pix_o       (pix),
    .colour_o    (colour),
    .pix_take_i  (pix_take)
  );

  cgpb_emit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .colour_i    (colour),
    .pix_take_o  (pix_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (out_addr),
    .out_data_o  (out_data),
    .out_last_o  (m_axis_tlast)
  );

  // pack output word
  assign m_axis_tdata = OUT_W'({out_data, out_addr});

endmodule

`default_nettype wire

// File: sv/cgpb_checker.sv
// ----------------------------------------------------------------------------
// cgpb_checker
// Port-level checks of the blitter output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpb_checker #(
  parameter int ADDR_BITS = cgpb_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [((ADDR_BITS+15)/8)*8-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast
);

  logic       out_acc;
  logic [1:0] burst_cnt_q;
  logic       open_q;
  logic [7:0] colour_q;
  logic [7:0] colour;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign colour  = m_axis_tdata[ADDR_BITS+7:ADDR_BITS];

  // words seen since the last word of a pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cnt_q <= 2'd0;
      open_q      <= 1'b0;
    end else if (out_acc) begin
      burst_cnt_q <= m_axis_tlast ? 2'd0 : burst_cnt_q + 2'd1;
      open_q      <= !m_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      colour_q <= colour;
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  // one pixel makes at most four writes
  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !m_axis_tlast) |-> (burst_cnt_q != 2'd3))
    else $error("more than four writes for one pixel");

  // all writes of one pixel carry the same colour
  a_burst_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && open_q) |-> (colour == colour_q))
    else $error("colour changed within one pixel");

endmodule

bind clipped_glyph_pixel_blit cgpb_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_cgpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/blit_write_checker.sv
// ----------------------------------------------------------------------------
// blit_write_checker
// Predicts and checks the framebuffer writes of the glyph blitter.
// ----------------------------------------------------------------------------
// Sits beside the blitter and watches all three channels. It keeps its own
// copy of the clip registers, the palette and the source counters. It works
// out the writes due for every word taken on the input side and matches each
// output word in order against the oldest write still due. Handshakes are
// sampled on the falling edge, where every signal is settled, and count for
// the rising edge that follows.

module blit_write_checker
  import cgpb_pkg::*;
(
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_valid_i,
  input  logic                                  s_ready_i,
  input  logic [IN_DATA_W-1:0]                  s_data_i,
  input  logic [MODE_W-1:0]                     s_user_i,
  input  logic                                  m_valid_i,
  input  logic                                  m_ready_i,
  input  logic [((ADDR_BITS_DEF+15)/8)*8-1:0]   m_data_i,
  input  logic                                  m_last_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam int TABLE_DEPTH = COLOUR_SETS_DEF * PIXEL_LEVELS_DEF;

  typedef struct packed {
    logic [ADDR_BITS_DEF-1:0] addr;
    logic [7:0]               data;
    logic                     last;
  } fb_write_t;

  fb_write_t  fb_writes_due[$];
  logic [7:0] palette [TABLE_DEPTH];
  int         col_pos;
  int         row_pos;
  cfg_t       regs;

  // writes caused by one input word, with palette and counter updates
  task automatic predict_fb_writes(input item_t it);
    int        hstep, vstep, src_w, src_h, base_x, base_y, px, py, dx, dy, n, k;
    int        clip_l, clip_t;
    logic      copy_r, copy_d, opaque;
    logic [7:0]  colour;
    logic [31:0] addr;
    fb_write_t made [4];
    if (it.mode == MODE_PALETTE) begin
      if (it.pixel != 0 && it.pixel <= PIXEL_LEVELS_DEF && it.colour_set < COLOUR_SETS_DEF)
        palette[it.colour_set * PIXEL_LEVELS_DEF + it.pixel - 1] = it.entry_value;
      return;
    end
    if (it.mode > MODE_BIG) return;

    hstep  = (it.mode == MODE_BIG) ? 2 : 1;
    vstep  = (it.mode == MODE_HIGH || it.mode == MODE_BIG) ? 2 : 1;
    copy_r = (it.mode == MODE_FAT || it.mode == MODE_BIG);
    copy_d = (it.mode == MODE_HIGH || it.mode == MODE_BIG);
    src_w  = int'(it.glyph_width) / hstep;
    src_h  = int'(it.glyph_height) / vstep;
    if (src_w == 0 || src_h == 0) return;
    if (src_w > SRC_MAX) src_w = SRC_MAX;
    if (src_h > SRC_MAX) src_h = SRC_MAX;

    base_x = int'($signed(it.glyph_x)) + int'($signed(regs.x_offset)) + col_pos * hstep;
    base_y = int'($signed(it.glyph_y)) + int'($signed(regs.y_offset)) + row_pos * vstep;

    opaque = it.pixel != 0 && it.pixel <= PIXEL_LEVELS_DEF &&
             it.colour_set < COLOUR_SETS_DEF;
    colour = '0;
    if (opaque) colour = palette[it.colour_set * PIXEL_LEVELS_DEF + it.pixel - 1];

    // raster advance, wrapping on the current source size
    if (col_pos + 1 >= src_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= src_h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end

    if (!opaque) return;

    // each copy clipped on its own, in (x,y) (x+1,y) (x,y+1) (x+1,y+1) order
    clip_l = int'(regs.clip_left);
    clip_t = int'(regs.clip_top);
    n = 0;
    for (dy = 0; dy <= int'(copy_d); dy++) begin
      for (dx = 0; dx <= int'(copy_r); dx++) begin
        px = base_x + dx;
        py = base_y + dy;
        if (px >= clip_l && px < clip_l + int'(regs.clip_width) &&
            py >= clip_t && py < clip_t + int'(regs.clip_height)) begin
          addr = py * int'(regs.row_stride) + px;
          made[n].addr = addr[ADDR_BITS_DEF-1:0];
          made[n].data = colour;
          made[n].last = 1'b0;
          n++;
        end
      end
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (k = 0; k < n; k++) fb_writes_due.push_back(made[k]);
  endtask

  always @(negedge clk_i) begin
    item_t     got_item;
    fb_write_t want;
    logic [ADDR_BITS_DEF-1:0] got_addr;
    logic [7:0]               got_data;
    if (!rst_ni) begin
      regs.clip_left   = '0;
      regs.clip_top    = '0;
      regs.clip_width  = 13'd320;
      regs.clip_height = 13'd200;
      regs.x_offset    = '0;
      regs.y_offset    = '0;
      regs.row_stride  = 13'd320;
      col_pos = 0;
      row_pos = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CLIP_LEFT:   regs.clip_left   = cfg_data_i[11:0];
          REG_CLIP_TOP:    regs.clip_top    = cfg_data_i[11:0];
          REG_CLIP_WIDTH:  regs.clip_width  = cfg_data_i;
          REG_CLIP_HEIGHT: regs.clip_height = cfg_data_i;
          REG_X_OFFSET:    regs.x_offset    = cfg_data_i[11:0];
          REG_Y_OFFSET:    regs.y_offset    = cfg_data_i[11:0];
          REG_ROW_STRIDE:  regs.row_stride  = cfg_data_i;
          default: ;
        endcase
      end

      // output word against the oldest write due
      if (m_valid_i && m_ready_i) begin
        got_addr = m_data_i[ADDR_BITS_DEF-1:0];
        got_data = m_data_i[ADDR_BITS_DEF+7 -: 8];
        if (fb_writes_due.size() == 0) begin
          $error("write with none due: write_addr %0h write_data %0h", got_addr, got_data);
          fail_count_o++;
        end else begin
          want = fb_writes_due.pop_front();
          if (got_addr !== want.addr) begin
            $error("write_addr: expected %0h, actual %0h", want.addr, got_addr);
            fail_count_o++;
          end
          if (got_data !== want.data) begin
            $error("write_data: expected %0h, actual %0h", want.data, got_data);
            fail_count_o++;
          end
          if (m_last_i !== want.last) begin
            $error("last_write: expected %0b, actual %0b", want.last, m_last_i);
            fail_count_o++;
          end
        end
      end

      // input word
      if (s_valid_i && s_ready_i) begin
        got_item.mode         = s_user_i;
        got_item.glyph_x      = s_data_i[11:0];
        got_item.glyph_y      = s_data_i[23:12];
        got_item.glyph_width  = s_data_i[30:24];
        got_item.glyph_height = s_data_i[37:31];
        got_item.colour_set   = s_data_i[41:38];
        got_item.pixel        = s_data_i[45:42];
        got_item.entry_value  = s_data_i[53:46];
        predict_fb_writes(got_item);
      end
    end
    pending_o = fb_writes_due.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the clipped glyph pixel blitter.
// ----------------------------------------------------------------------------
// After reset a directed run covers palette writes, every mode, clip edges,
// dropped words, degenerate and oversized glyphs and a geometry change in the
// middle of a glyph. Five phases follow, each under its own clip setting,
// sending mostly whole glyphs with random pixels, plus stray palette words,
// unused modes and cut-off glyphs. Sender and receiver stall at random; one
// long receiver hold fills the block and one pause lets it run dry.

module tb;
  import cgpb_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 12;
  localparam int PHASES       = 5;
  localparam int TABLE_DEPTH  = COLOUR_SETS_DEF * PIXEL_LEVELS_DEF;
  localparam int OUT_W        = ((ADDR_BITS_DEF + 15) / 8) * 8;
  localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_W'(MODE_BIG + 1);
  localparam logic [MODE_W-1:0] MODE_LAST_UNUSED  = MODE_W'((1 << MODE_W) - 1);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int   fail_count;
  int   writes_pending;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  logic pal_written [TABLE_DEPTH];
  cfg_t phase_cfg [PHASES];

  clipped_glyph_pixel_blit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  blit_write_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (writes_pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(negedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                    (cfg_valid_i && cfg_ready_o))) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  function automatic cfg_t make_cfg(input int left, input int top, input int width,
                                    input int height, input int xoff, input int yoff,
                                    input int stride);
    cfg_t c;
    c.clip_left   = 12'(left);
    c.clip_top    = 12'(top);
    c.clip_width  = 13'(width);
    c.clip_height = 13'(height);
    c.x_offset    = 12'(xoff);
    c.y_offset    = 12'(yoff);
    c.row_stride  = 13'(stride);
    return c;
  endfunction

  // glyph origin near either clip edge, or anywhere
  function automatic logic [11:0] pick_origin(input int lo, input int len,
                                              input logic [11:0] offset);
    int v;
    case ($urandom_range(0, 2))
      0:       v = lo - int'($signed(offset)) + int'($urandom_range(0, 12)) - 6;
      1:       v = lo + len - int'($signed(offset)) - int'($urandom_range(0, 12));
      default: v = int'($signed(12'($urandom)));
    endcase
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return 12'(v);
  endfunction

  // one input word; valid stays high between back-to-back words
  task automatic send_word(input item_t it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {2'b00, it.entry_value, it.pixel, it.colour_set, it.glyph_height,
                      it.glyph_width, it.glyph_y, it.glyph_x};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic send_palette(input logic [3:0] cs, input logic [3:0] lvl,
                              input logic [7:0] value);
    item_t it;
    it.mode         = MODE_PALETTE;
    it.glyph_x      = 12'($urandom);
    it.glyph_y      = 12'($urandom);
    it.glyph_width  = 7'($urandom);
    it.glyph_height = 7'($urandom);
    it.colour_set   = cs;
    it.pixel        = lvl;
    it.entry_value  = value;
    send_word(it);
    if (lvl != 0) begin
      pal_written[cs * PIXEL_LEVELS_DEF + lvl - 1] = 1'b1;
      items_sent++;
    end
  endtask

  // unused modes: random content, dropped by the block
  task automatic send_ignored(input logic [MODE_W-1:0] mode);
    item_t       it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.mode = mode;
    send_word(it);
  endtask

  // a glyph pixel; its palette entry is filled first if still unwritten
  task automatic send_pixel(input logic [MODE_W-1:0] mode, input logic [11:0] gx,
                            input logic [11:0] gy, input logic [6:0] gw,
                            input logic [6:0] gh, input logic [3:0] cs,
                            input logic [3:0] lvl);
    item_t it;
    if (lvl != 0 && !pal_written[cs * PIXEL_LEVELS_DEF + lvl - 1])
      send_palette(cs, lvl, 8'($urandom));
    it.mode         = mode;
    it.glyph_x      = gx;
    it.glyph_y      = gy;
    it.glyph_width  = gw;
    it.glyph_height = gh;
    it.colour_set   = cs;
    it.pixel        = lvl;
    it.entry_value  = 8'($urandom);
    send_word(it);
    items_sent++;
  endtask

  // a 1x1 normal pixel always brings both source counters back to zero
  task automatic send_resync();
    send_pixel(MODE_NORMAL, 12'($urandom), 12'($urandom), 7'd1, 7'd1, 4'($urandom), 4'd0);
  endtask

  task automatic send_glyph(input logic [MODE_W-1:0] mode, input cfg_t c, input logic cut);
    logic [11:0] gx, gy;
    logic [6:0]  gw, gh;
    logic [3:0]  cs, lvl;
    int          src_w, src_h, count, k;
    gw    = 7'($urandom_range(1, 5));
    gh    = 7'($urandom_range(1, 5));
    cs    = 4'($urandom);
    gx    = pick_origin(int'(c.clip_left), int'(c.clip_width), c.x_offset);
    gy    = pick_origin(int'(c.clip_top), int'(c.clip_height), c.y_offset);
    src_w = int'(gw) / ((mode == MODE_BIG) ? 2 : 1);
    src_h = int'(gh) / ((mode == MODE_HIGH || mode == MODE_BIG) ? 2 : 1);
    count = src_w * src_h;
    // a degenerate glyph still sends one word, which the block drops
    if (count == 0) count = 1;
    if (cut && count > 1) count = $urandom_range(1, count - 1);
    for (k = 0; k < count; k++) begin
      lvl = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      send_pixel(mode, gx, gy, gw, gh, cs, lvl);
    end
    if (cut) send_resync();
  endtask

  // stop sending and let every due write come out
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (writes_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_CLIP_LEFT, 13'(c.clip_left));
    write_reg(REG_CLIP_TOP, 13'(c.clip_top));
    write_reg(REG_CLIP_WIDTH, c.clip_width);
    write_reg(REG_CLIP_HEIGHT, c.clip_height);
    write_reg(REG_X_OFFSET, 13'(c.x_offset));
    write_reg(REG_Y_OFFSET, 13'(c.y_offset));
    write_reg(REG_ROW_STRIDE, c.row_stride);
    cfg_valid_i <= 1'b0;
  endtask

  // directed run, clip 320x200 at the origin, stride 320, no offsets
  task automatic run_directed();
    int k;
    send_palette(4'd0, 4'd1, 8'h00);
    send_palette(4'd15, 4'd15, 8'hFF);
    send_palette(4'd5, 4'd8, 8'hA5);
    send_palette(4'd10, 4'd4, 8'h5A);
    // level zero is out of range and dropped
    send_palette(4'd3, 4'd0, 8'h77);
    for (k = 0; k < 3; k++) send_ignored(MODE_W'(MODE_FIRST_UNUSED + k));
    send_pixel(MODE_NORMAL, 12'd0, 12'd0, 7'd1, 7'd1, 4'd0, 4'd1);
    // right copy lands just past the clip edge
    send_pixel(MODE_FAT, 12'd319, 12'd10, 7'd1, 7'd1, 4'd15, 4'd15);
    // lower copy lands just below the clip
    send_pixel(MODE_HIGH, 12'd5, 12'd199, 7'd1, 7'd2, 4'd5, 4'd8);
    // big 2x4: first block fully inside, second fully below
    send_pixel(MODE_BIG, 12'd318, 12'd198, 7'd2, 7'd4, 4'd10, 4'd4);
    send_pixel(MODE_BIG, 12'd318, 12'd198, 7'd2, 7'd4, 4'd15, 4'd15);
    // transparent pixel
    send_pixel(MODE_NORMAL, 12'd1, 12'd1, 7'd1, 7'd1, 4'd15, 4'd0);
    // zero source width or height
    send_pixel(MODE_BIG, 12'd20, 12'd20, 7'd1, 7'd2, 4'd0, 4'd1);
    send_pixel(MODE_HIGH, 12'd20, 12'd20, 7'd1, 7'd1, 4'd0, 4'd1);
    send_pixel(MODE_NORMAL, 12'd20, 12'd20, 7'd0, 7'd0, 4'd0, 4'd1);
    // coordinate extremes, both clipped
    send_pixel(MODE_NORMAL, 12'h800, 12'h800, 7'd1, 7'd1, 4'd15, 4'd15);
    send_pixel(MODE_NORMAL, 12'h7FF, 12'h7FF, 7'd1, 7'd1, 4'd15, 4'd15);
    // oversized glyph counts as 64 wide and leaves the column at one
    send_pixel(MODE_NORMAL, 12'd0, 12'd0, 7'd127, 7'd127, 4'd0, 4'd1);
    // geometry switch mid-glyph: placed at column one of a fat glyph
    send_pixel(MODE_FAT, 12'd2, 12'd2, 7'd3, 7'd1, 4'd5, 4'd8);
    send_resync();
  endtask

  // one random step: mostly whole glyphs, some noise and cut-off glyphs
  task automatic random_step(input cfg_t c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_palette(4'($urandom), 4'($urandom), 8'($urandom));
    end else if (r < 15) begin
      send_ignored(MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED)));
    end else if (r < 22) begin
      send_pixel(MODE_W'($urandom_range(MODE_NORMAL, MODE_BIG)), 12'($urandom),
                 12'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), 4'($urandom));
      send_resync();
    end else begin
      send_glyph(MODE_W'($urandom_range(MODE_NORMAL, MODE_BIG)), c,
                 $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    int   p, phase_end;
    logic paused;
    paused = 1'b0;
    foreach (pal_written[k]) pal_written[k] = 1'b0;
    phase_cfg[0] = make_cfg(0, 0, 320, 200, 0, 0, 320);
    phase_cfg[1] = make_cfg(10, 5, 20, 12, -3, 7, 64);
    phase_cfg[2] = make_cfg(4095, 4095, 8191, 8191, 2047, 2047, 8191);
    phase_cfg[3] = make_cfg(0, 0, 0, 0, -2048, -2048, 1);
    phase_cfg[4] = make_cfg(100, 50, 4096, 4096, -100, 30, 4096);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < PHASES; p++) begin
      drain_writes();
      apply_config(phase_cfg[p]);
      // sender light and receiver heavy, then swapped, then no stalls
      if (p < 2) begin
        tx_idle_pct = 35;
        rx_idle_pct <= 61;
      end else if (p < 4) begin
        tx_idle_pct = 61;
        rx_idle_pct <= 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        // long receiver hold while words keep coming
        hold_req <= ~hold_req;
      end
      if (p == 0) run_directed();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (p == 2 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          drain_writes();
          paused = 1'b1;
        end
        random_step(phase_cfg[p]);
      end
    end

    drain_writes();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && writes_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
